### rtl/utf8dec_pkg.sv
// Shared types and constants for the UTF-8 decoder with raw-byte fallback.
// Used by utf8dec_core, utf8dec_queue and the top level; depends on nothing.
package utf8dec_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CpW        = 21;
  localparam int unsigned MaxRes     = 4;
  localparam int unsigned ResCntW    = 3;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned InTdataW   = 8;
  localparam int unsigned OutTdataW  = 24;

  // Byte classes.
  localparam logic [ByteW-1:0] LeadMin  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Min = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Min = 8'hF0;
  localparam logic [ByteW-1:0] ContMask = 8'hC0;
  localparam logic [ByteW-1:0] ContTag  = 8'h80;
  localparam logic [ByteW-1:0] LeadKeep = 8'h7F;

  // Sequence length codes; zero means no sequence is open.
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  typedef logic [CpW-1:0] cp_t;

  // Results caused by one input byte, in order from index zero.
  typedef struct packed {
    logic [ResCntW-1:0]    cnt;
    cp_t [MaxRes-1:0]      cp;
    logic                  last;
  } res_t;

endpackage

### rtl/utf8_decoder_raw_fallback.sv
// UTF-8 decoder with raw-byte fallback: one byte per request, one code point per result.
// A byte's results are written into the result queue and reach the master side from there.
// Throughput: one byte per cycle while the queue has room; a broken sequence yields
// up to four results that drain one per cycle while the master side is ready, through
// an eight-entry result queue, which stalls input once it holds more than four waiting
// results. Reset (rst_ni low, asynchronous) closes any open sequence and empties the queue.
// Depends on utf8dec_pkg, utf8dec_core and utf8dec_queue.
module utf8_decoder_raw_fallback #(
  parameter int unsigned QDepth = utf8dec_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [utf8dec_pkg::InTdataW-1:0]    s_tdata_i,  // [7:0] byte_in
  input  logic                                s_tlast_i,  // last_in
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [utf8dec_pkg::OutTdataW-1:0]   m_tdata_o,  // [20:0] code_point, [23:21] zero
  output logic                                m_tlast_o   // last_out
);
  import utf8dec_pkg::*;

  logic accept;
  res_t res;
  cp_t  out_cp;

  assign accept = s_tvalid_i && s_tready_o;

  utf8dec_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_tdata_i[ByteW-1:0]),
    .last_i   (s_tlast_i),
    .res_o    (res)
  );

  utf8dec_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .ready_o     (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_cp_o    (out_cp),
    .out_last_o  (m_tlast_o)
  );

  assign m_tdata_o = {(OutTdataW - CpW)'(0), out_cp};

endmodule

### rtl/utf8dec_core.sv
// Decoder state and per-byte decode logic: turns one byte into zero to four results.
// Depends on utf8dec_pkg.
module utf8dec_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [utf8dec_pkg::ByteW-1:0] byte_i,
  input  logic                        last_i,
  output utf8dec_pkg::res_t           res_o
);
  import utf8dec_pkg::*;

  logic [ByteW-1:0] lead_q, lead_d;
  logic [2:0]       exp_q, exp_d;
  logic [1:0]       hc_q, hc_d;
  logic [ByteW-1:0] held_q [2];
  logic             hw_en;
  logic             hw_idx;

  always_comb begin
    logic [ResCntW-1:0] n;
    logic               fresh;
    logic               cont;
    cp_t                cp;

    lead_d = lead_q;
    exp_d  = exp_q;
    hc_d   = hc_q;
    hw_en  = 1'b0;
    hw_idx = hc_q[0];
    res_o  = '0;
    n      = '0;
    fresh  = 1'b1;
    cont   = (byte_i & ContMask) == ContTag;
    cp     = '0;

    if (exp_q != LenNone) begin
      if (cont) begin
        fresh = 1'b0;
        if (({1'b0, hc_q} + 3'd2) == exp_q) begin
          // Sequence complete: keep the lead's payload bits, append six per byte.
          cp = cp_t'(lead_q & (LeadKeep >> exp_q));
          for (int i = 0; i < 2; i++) begin
            if (2'(i) < hc_q) begin
              cp = {cp[CpW-7:0], held_q[i][5:0]};
            end
          end
          cp = {cp[CpW-7:0], byte_i[5:0]};
          res_o.cp[0] = cp;
          n      = 3'd1;
          lead_d = '0;
          exp_d  = LenNone;
          hc_d   = '0;
        end else if (last_i) begin
          // Stream ends inside the sequence: everything goes out raw.
          res_o.cp[n[1:0]] = cp_t'(lead_q);
          n = n + 3'd1;
          for (int i = 0; i < 2; i++) begin
            if (2'(i) < hc_q) begin
              res_o.cp[n[1:0]] = cp_t'(held_q[i]);
              n = n + 3'd1;
            end
          end
          res_o.cp[n[1:0]] = cp_t'(byte_i);
          n      = n + 3'd1;
          lead_d = '0;
          exp_d  = LenNone;
          hc_d   = '0;
        end else begin
          hw_en = 1'b1;
          hc_d  = hc_q + 2'd1;
        end
      end else begin
        // Broken sequence: flush lead and held bytes, then treat this byte as new.
        res_o.cp[n[1:0]] = cp_t'(lead_q);
        n = n + 3'd1;
        for (int i = 0; i < 2; i++) begin
          if (2'(i) < hc_q) begin
            res_o.cp[n[1:0]] = cp_t'(held_q[i]);
            n = n + 3'd1;
          end
        end
        lead_d = '0;
        exp_d  = LenNone;
        hc_d   = '0;
      end
    end

    if (fresh) begin
      if (byte_i < LeadMin || last_i) begin
        res_o.cp[n[1:0]] = cp_t'(byte_i);
        n = n + 3'd1;
      end else begin
        lead_d = byte_i;
        exp_d  = (byte_i >= Lead4Min) ? Len4 : ((byte_i >= Lead3Min) ? Len3 : Len2);
        hc_d   = '0;
      end
    end

    res_o.cnt  = n;
    res_o.last = last_i && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      exp_q  <= LenNone;
      hc_q   <= '0;
    end else if (accept_i) begin
      lead_q <= lead_d;
      exp_q  <= exp_d;
      hc_q   <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && hw_en) begin
      held_q[hw_idx] <= byte_i;
    end
  end

  // An open sequence always has room for at least one more continuation.
  a_open_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q != LenNone |-> ({1'b0, hc_q} + 3'd2) <= exp_q)
    else $error("held count went past the sequence length");

  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q == LenNone |-> (hc_q == 2'd0 && lead_q == '0))
    else $error("closed sequence left state behind");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> exp_q == LenNone)
    else $error("sequence open after end of stream");

endmodule

### rtl/utf8dec_queue.sv
// Result queue: takes a burst of up to four results in one cycle and drains one per
// cycle while out_ready_i is high. Depends on utf8dec_pkg.
module utf8dec_queue #(
  parameter int unsigned QDepth = utf8dec_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  utf8dec_pkg::res_t     res_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output utf8dec_pkg::cp_t      out_cp_o,
  output logic                  out_last_o
);
  import utf8dec_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cp_t             cp_q   [QDepth];
  logic            last_q [QDepth];
  logic [PtrW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != '0;
  assign out_cp_o    = cp_q[rd_q];
  assign out_last_o  = last_q[rd_q];
  // Accept only while a full burst is sure to fit.
  assign ready_o     = count_q <= CntW'(QDepth - MaxRes);

  always_comb begin
    rd_d    = pop ? rd_q + PtrW'(1) : rd_q;
    wr_d    = push_i ? wr_q + PtrW'(res_i.cnt) : wr_q;
    count_d = count_q + (push_i ? CntW'(res_i.cnt) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (push_i && ResCntW'(k) < res_i.cnt) begin
        cp_q[wr_q + PtrW'(k)]   <= res_i.cp[k];
        last_q[wr_q + PtrW'(k)] <= res_i.last && (ResCntW'(k + 1) == res_i.cnt);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QDepth))
    else $error("result queue overfilled");

  a_burst_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ({1'b0, count_q} + (CntW + 1)'(res_i.cnt)) <= (CntW + 1)'(QDepth))
    else $error("burst written into a queue without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push_i |=> count_q == $past(count_q) - CntW'(1))
    else $error("queue count wrong after a lone pop");

endmodule

### verif/utf8_decode_checker.sv
// Checker for the UTF-8 decoder with raw-byte fallback: watches both stream channels,
// predicts the code points of every accepted request and compares them in order.
// Depends on utf8dec_pkg for widths and byte-class constants.
module utf8_decode_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [utf8dec_pkg::InTdataW-1:0]  s_tdata_i,
  input  logic                              s_tlast_i,
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  input  logic [utf8dec_pkg::OutTdataW-1:0] m_tdata_i,
  input  logic                              m_tlast_i,
  output int                                mismatch_cnt_o,
  output int                                pending_o,
  output int                                cp_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import utf8dec_pkg::*;

  typedef struct packed {
    cp_t  cp;
    logic fin;
  } cp_exp_t;

  cp_exp_t cp_expect_q[$];

  // Decoder state as the predictor sees it.
  logic [ByteW-1:0] seq_lead;
  logic [2:0]       seq_len;
  logic [ByteW-1:0] seq_held [2];
  logic [1:0]       seq_held_cnt;

  // Channel activity captured mid-cycle, when every signal has settled.
  logic                 in_fire  = 1'b0;
  logic                 out_fire = 1'b0;
  logic [ByteW-1:0]     in_byte;
  logic                 in_fin;
  logic [OutTdataW-1:0] out_data;
  logic                 out_fin;

  task automatic report(input string what);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= 30) $display("[%0t] ERROR: %s", $time, what);
  endtask

  task automatic close_seq();
    seq_lead     = '0;
    seq_len      = LenNone;
    seq_held_cnt = '0;
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic fin);
    cp_t     res [MaxRes];
    int      n;
    int      i;
    logic    fresh;
    logic    is_cont;
    cp_t     acc;
    cp_exp_t item;
    n       = 0;
    fresh   = 1'b1;
    is_cont = (b & ContMask) == ContTag;
    if (seq_len != LenNone) begin
      if (is_cont && ({1'b0, seq_held_cnt} + 3'd2 == seq_len)) begin
        acc = cp_t'(seq_lead & (LeadKeep >> seq_len));
        for (i = 0; i < seq_held_cnt; i++) acc = (acc << 6) | cp_t'(seq_held[i][5:0]);
        acc = (acc << 6) | cp_t'(b[5:0]);
        res[n] = acc;
        n++;
        close_seq();
        fresh = 1'b0;
      end else if (is_cont && !fin) begin
        seq_held[seq_held_cnt[0]] = b;
        seq_held_cnt++;
        fresh = 1'b0;
      end else begin
        // A broken or cut-off sequence goes out raw; the current byte is then
        // treated as if no sequence had been open.
        res[n] = cp_t'(seq_lead);
        n++;
        for (i = 0; i < seq_held_cnt; i++) begin
          res[n] = cp_t'(seq_held[i]);
          n++;
        end
        close_seq();
      end
    end
    if (fresh) begin
      if (b < LeadMin || fin) begin
        res[n] = cp_t'(b);
        n++;
      end else begin
        seq_lead     = b;
        seq_len      = (b >= Lead4Min) ? Len4 : ((b >= Lead3Min) ? Len3 : Len2);
        seq_held_cnt = '0;
      end
    end
    for (i = 0; i < n; i++) begin
      item.cp     = res[i];
      item.fin    = fin && (i == n - 1);
      cp_expect_q = {cp_expect_q, item};
    end
  endtask

  always @(negedge clk_i) begin
    in_fire  = rst_ni && s_tvalid_i && s_tready_i;
    in_byte  = s_tdata_i[ByteW-1:0];
    in_fin   = s_tlast_i;
    out_fire = rst_ni && m_tvalid_i && m_tready_i;
    out_data = m_tdata_i;
    out_fin  = m_tlast_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    cp_exp_t exp_cp;
    if (!rst_ni) begin
      close_seq();
      cp_expect_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
      cp_checked_o   = 0;
    end else begin
      // Results leave before the new request is predicted: a result taken at this
      // edge never belongs to the byte taken at the same edge.
      if (out_fire) begin
        if (cp_expect_q.size() == 0) begin
          report($sformatf("unexpected result: code point %h last %b",
                           out_data[CpW-1:0], out_fin));
        end else begin
          exp_cp = cp_expect_q.pop_front();
          if (out_data[CpW-1:0] !== exp_cp.cp)
            report($sformatf("code point %h, expected %h", out_data[CpW-1:0], exp_cp.cp));
          if (out_data[OutTdataW-1:CpW] !== '0)
            report($sformatf("pad bits %b not zero", out_data[OutTdataW-1:CpW]));
          if (out_fin !== exp_cp.fin)
            report($sformatf("last %b, expected %b on code point %h",
                             out_fin, exp_cp.fin, exp_cp.cp));
        end
        cp_checked_o++;
      end
      if (in_fire) decode_byte(in_byte, in_fin);
      pending_o = cp_expect_q.size();
    end
  end

endmodule

### verif/tb_utf8_decoder_raw_fallback.sv
// Testbench top for utf8_decoder_raw_fallback: drives byte streams with bursts and gaps,
// stalls the result side, and gives the verdict from utf8_decode_checker.
// Depends on utf8dec_pkg, the decoder RTL and verif/utf8_decode_checker.sv.
module tb_utf8_decoder_raw_fallback;
  timeunit 1ns;
  timeprecision 1ps;
  import utf8dec_pkg::*;

  localparam int ByteTarget = 450;
  localparam int CycleLimit = 200000;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 s_tvalid_i = 1'b0;
  logic [InTdataW-1:0]  s_tdata_i  = '0;
  logic                 s_tlast_i  = 1'b0;
  logic                 m_tready_i = 1'b0;
  logic                 s_tready_o;
  logic                 m_tvalid_o;
  logic [OutTdataW-1:0] m_tdata_o;
  logic                 m_tlast_o;

  int mismatch_cnt;
  int pending_cnt;
  int cp_checked;
  int bytes_sent   = 0;
  int streams_sent = 0;
  int burst_left   = 1;
  int rx_mode      = 0;
  int rx_left      = 0;
  int cycles;

  logic [ByteW-1:0] stream_q[$];
  logic [8:0]       directed_q[$];  // {last, byte}

  always #10 clk_i = ~clk_i;

  utf8_decoder_raw_fallback dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  utf8_decode_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_tvalid_i),
    .s_tready_i     (s_tready_o),
    .s_tdata_i      (s_tdata_i),
    .s_tlast_i      (s_tlast_i),
    .m_tvalid_i     (m_tvalid_o),
    .m_tready_i     (m_tready_i),
    .m_tdata_i      (m_tdata_o),
    .m_tlast_i      (m_tlast_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt),
    .cp_checked_o   (cp_checked)
  );

  // Result side: always ready, random stalls, or mostly stalled, each for a while.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       m_tready_i <= 1'b1;
      1:       m_tready_i <= ($urandom_range(0, 1) == 1);
      default: m_tready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d code points outstanding.",
             cycles, pending_cnt);
    $display("utf8_decoder_raw_fallback: mismatch");
    $finish;
  end

  // Holds one request until it is taken; between bursts the sender may go quiet.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic fin);
    logic rdy;
    int   gap;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tlast_i  <= fin;
    do begin
      @(negedge clk_i);
      rdy = s_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        s_tdata_i  <= ByteW'($urandom);
        s_tlast_i  <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_for_results();
    s_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    @(posedge clk_i);
  endtask

  // A stream mixes ASCII, complete sequences, cut-short sequences and noise bytes.
  task automatic build_stream();
    int          n_chars;
    int          kind;
    int          keep;
    logic [2:0]  len;
    logic [ByteW-1:0] lead;
    stream_q.delete();
    n_chars = $urandom_range(1, 10);
    repeat (n_chars) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        stream_q = {stream_q, ByteW'($urandom_range(0, 127))};
      end else if (kind < 90) begin
        len = 3'($urandom_range(2, 4));
        case (len)
          Len2:    lead = ByteW'($urandom_range(8'hC0, 8'hDF));
          Len3:    lead = ByteW'($urandom_range(8'hE0, 8'hEF));
          default: lead = ByteW'($urandom_range(8'hF0, 8'hFF));
        endcase
        keep = (kind < 78) ? len - 1 : $urandom_range(0, len - 2);
        stream_q = {stream_q, lead};
        repeat (keep) stream_q = {stream_q, ByteW'($urandom_range(8'h80, 8'hBF))};
      end else begin
        stream_q = {stream_q, ByteW'($urandom)};
      end
    end
  endtask

  initial begin
    bit mid_pause;
    mid_pause  = 1'b0;
    directed_q = '{
      9'h000, 9'h07F,                   // ASCII extremes
      9'h0C2, 9'h0A9,                   // two-byte sequence
      9'h0E2, 9'h082, 9'h0AC,           // three-byte sequence
      9'h0F0, 9'h09F, 9'h098, 9'h080,   // four-byte sequence
      9'h0FF, 9'h080, 9'h0BF, 9'h0BF,   // top lead byte still opens four bytes
      9'h080,                           // stray continuation
      9'h0E2, 9'h082, 9'h041,           // sequence broken by ASCII
      9'h0F0, 9'h09F, 9'h098, 9'h0C3, 9'h0A9,  // broken by a new lead, three raw
      9'h0F0, 9'h09F, 9'h098, 9'h041,   // broken by ASCII, four results at once
      9'h0E2, 9'h182,                   // stream ends inside a sequence
      9'h1C3                            // lead as the final byte
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_byte(directed_q[i][7:0], directed_q[i][8]);
    wait_for_results();

    while (bytes_sent < ByteTarget) begin
      build_stream();
      foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
      streams_sent++;
      if (!mid_pause && bytes_sent >= ByteTarget / 2) begin
        wait_for_results();
        mid_pause = 1'b1;
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d directed and %0d random bytes over %0d random streams;",
             directed_q.size(), bytes_sent - directed_q.size(), streams_sent);
    $display("%0d code points checked, %0d errors, %0d never arrived.",
             cp_checked, mismatch_cnt, pending_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("utf8_decoder_raw_fallback: match");
    end else begin
      $display("utf8_decoder_raw_fallback: mismatch");
    end
    $finish;
  end

endmodule
